// ===== src/line_reverser_top_assert.svh =====
// assertion macros for the line reverser checker
// no dependencies; included by files that hold concurrent assertions
`ifndef LINE_REVERSER_TOP_ASSERT_SVH
`define LINE_REVERSER_TOP_ASSERT_SVH

// checked only while out of reset
`define LR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define LR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/lr_pkg.sv =====
// shared types and constants for the line reverser
// no dependencies; used by the top level, the controller, the datapath and the checker
package lr_pkg;

  localparam int LINE_LIMIT  = 64;
  localparam int STORE_DEPTH = LINE_LIMIT - 1;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CHAR_W      = 8;

  localparam logic [CHAR_W-1:0] NEWLINE_BYTE = 8'h0A;

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              end_of_input;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              last_of_run;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic wr_en;
    logic cnt_inc;
    logic cnt_clr;
    logic idx_ld_cur;
    logic idx_ld_dec;
    logic idx_dec;
    logic out_load;
    logic out_nl;
    logic out_last;
  } lr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic cnt_last;
    logic idx_zero;
    logic out_free;
  } lr_status_t;

endpackage

// ===== src/line_reverser_top.sv =====
// line reverser: buffered character words are sent back reversed per line, or per
// chunk when the line store fills. each buffered word of a burst goes through a ram
// read, then an output load; a burst opened by a newline ends with a newline word.
// input stalls during a burst. synchronous active-low reset empties the line
// and the output register; the line store itself is not cleared.
module line_reverser_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lr_pkg::in_word_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lr_pkg::out_word_t out_data
);

  lr_pkg::lr_cmd_t    cmd;
  lr_pkg::lr_status_t status;

  lr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .status  (status),
    .cmd     (cmd)
  );

  lr_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// ===== src/lr_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module lr_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/lr_ctrl.sv =====
// controller state machine: classifies input words and sequences each burst
// depends on lr_pkg
module lr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lr_pkg::in_word_t  in_data,
  input  lr_pkg::lr_status_t status,
  output lr_pkg::lr_cmd_t   cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_OUT  = 4'b0100,
    ST_NL   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   nl_pend_r, nl_pend_nxt;
  logic   accept;
  logic   is_nl;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_nl    = (in_data.char_in == lr_pkg::NEWLINE_BYTE);

  always_comb begin
    state_nxt   = state_r;
    nl_pend_nxt = nl_pend_r;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (in_data.end_of_input) begin
            if (!status.cnt_zero) begin
              cmd.idx_ld_dec = 1'b1;
              cmd.cnt_clr    = 1'b1;
              nl_pend_nxt    = 1'b0;
              state_nxt      = ST_RD;
            end
          end else if (is_nl) begin
            cmd.cnt_clr = 1'b1;
            nl_pend_nxt = 1'b1;
            if (status.cnt_zero) begin
              state_nxt = ST_NL;
            end else begin
              cmd.idx_ld_dec = 1'b1;
              state_nxt      = ST_RD;
            end
          end else begin
            cmd.wr_en = 1'b1;
            if (status.cnt_last) begin
              // buffer full: release the chunk including this character
              cmd.idx_ld_cur = 1'b1;
              cmd.cnt_clr    = 1'b1;
              nl_pend_nxt    = 1'b0;
              state_nxt      = ST_RD;
            end else begin
              cmd.cnt_inc = 1'b1;
            end
          end
        end
      end
      ST_RD: begin
        // read address presented this cycle, data valid next
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = status.idx_zero && !nl_pend_r;
          if (status.idx_zero) begin
            state_nxt = nl_pend_r ? ST_NL : ST_IDLE;
          end else begin
            cmd.idx_dec = 1'b1;
            state_nxt   = ST_RD;
          end
        end
      end
      ST_NL: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_nl   = 1'b1;
          cmd.out_last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      nl_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      nl_pend_r <= nl_pend_nxt;
    end
  end

endmodule

// ===== src/lr_dp.sv =====
// datapath: line store, fill count, read index and output register
// depends on lr_pkg and lr_ram
module lr_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  lr_pkg::in_word_t   in_data,
  input  lr_pkg::lr_cmd_t    cmd,
  output lr_pkg::lr_status_t status,
  output logic               out_valid,
  input  logic               out_stall,
  output lr_pkg::out_word_t  out_data
);

  logic [lr_pkg::ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [lr_pkg::ADDR_W-1:0] idx_r, idx_nxt;
  logic [lr_pkg::CHAR_W-1:0] rd_data;
  logic                      out_valid_r, out_valid_nxt;
  lr_pkg::out_word_t         out_data_r, out_data_nxt;

  lr_ram #(
    .WIDTH(lr_pkg::CHAR_W),
    .DEPTH(lr_pkg::STORE_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (cmd.wr_en),
    .wr_addr(cnt_r),
    .wr_data(in_data.char_in),
    .rd_addr(idx_r),
    .rd_data(rd_data)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    priority if (cmd.idx_ld_cur) begin
      idx_nxt = cnt_r;
    end else if (cmd.idx_ld_dec) begin
      idx_nxt = cnt_r - 1'b1;
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_r - 1'b1;
    end
  end

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.char_out = cmd.out_nl ? lr_pkg::NEWLINE_BYTE : rd_data;
      out_data_nxt.last_of_run = cmd.out_last;
    end
  end

  assign status.cnt_zero = (cnt_r == '0);
  assign status.cnt_last = (cnt_r == lr_pkg::ADDR_W'(lr_pkg::STORE_DEPTH - 1));
  assign status.idx_zero = (idx_r == '0);
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== src/lr_checker.sv =====
// port-level checks for the line reverser, bound to the top level
// depends on lr_pkg and line_reverser_top_assert.svh
`include "line_reverser_top_assert.svh"

module lr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input lr_pkg::in_word_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input lr_pkg::out_word_t out_data
);

  logic nl_accept;

  assign nl_accept = in_valid && !in_stall && !in_data.end_of_input &&
                     (in_data.char_in == lr_pkg::NEWLINE_BYTE);

  `LR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled output word changed")

  `LR_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "output word valid right after reset")

  // a newline always opens a burst, so the input stalls next
  `LR_ASSERT(a_nl_stalls, nl_accept |=> in_stall, "no burst after a newline")

  // newlines are never buffered, so an output newline closes its burst
  `LR_ASSERT(a_nl_last, out_valid && (out_data.char_out == lr_pkg::NEWLINE_BYTE) |-> out_data.last_of_run, "newline word without last mark")

endmodule

bind line_reverser_top lr_checker u_lr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
